// ----- src/mrr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants for the MODBUS RTU read-input-registers master.
// ----------------------------------------------------------------------------
package mrr_pkg;

   // default sizing
   localparam int MAX_REGS_DEF       = 16;
   localparam int RESPONSE_BYTES_DEF = 64;

   // fixed field widths
   localparam int WCOUNT_W   = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // protocol constants
   localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] LOW_BYTE_MASK   = 16'h00FF;

   // response byte offsets
   localparam int POS_FUNC       = 1;
   localparam int POS_BYTE_COUNT = 2;
   localparam int POS_DATA       = 3;

   // input item kinds
   localparam logic [1:0] KIND_REQUEST   = 2'd0;
   localparam logic [1:0] KIND_RX_BYTE   = 2'd1;
   localparam logic [1:0] KIND_FRAME_END = 2'd2;

   // result kinds
   localparam logic [1:0] RK_TX_BYTE = 2'd0;
   localparam logic [1:0] RK_WORD    = 2'd1;
   localparam logic [1:0] RK_STATUS  = 2'd2;

   // transaction status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_RESPONSE = 2'd1;
   localparam logic [1:0] ST_EXCEPTION   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW    = 2'd3;

   // CSR register index
   localparam logic REG_SLAVE_ADDRESS = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CRC,
      S_TX,
      S_RD1,
      S_RD2,
      S_STAT,
      S_WHI,
      S_WLO,
      S_WOUT
   } state_type;

   typedef struct packed {
      logic init;
      logic shift;
   } crc_ctrl_type;

   typedef struct packed {
      logic clear;
      logic write;
   } rxbuf_ctrl_type;

endpackage

// ----- src/mrr_crc.sv -----
// ----------------------------------------------------------------------------
// mrr_crc
// Bit-serial CRC-16/MODBUS engine, one data bit per cycle while shift is set, LSB first.
// ----------------------------------------------------------------------------
module mrr_crc
   import mrr_pkg::*;
(
   input  logic         clock,
   input  crc_ctrl_type ctrl,
   input  logic         data_bit,
   output logic [15:0]  crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] shifted;
   logic        feedback;

   always_comb begin
      feedback = crc_ff[0] ^ data_bit;
      shifted  = {1'b0, crc_ff[15:1]};
      if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.shift) begin
         crc_in = feedback ? (shifted ^ CRC_POLY) : shifted;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

// ----- src/mrr_rxbuf.sv -----
// ----------------------------------------------------------------------------
// mrr_rxbuf
// Receive byte buffer with fill count; unfilled positions read as zero.
// ----------------------------------------------------------------------------
module mrr_rxbuf
   import mrr_pkg::*;
#(
   parameter int DEPTH = RESPONSE_BYTES_DEF,
   parameter int POS_W = 7
)
(
   input  logic             clock,
   input  logic             reset,
   input  rxbuf_ctrl_type   ctrl,
   input  logic [7:0]       wr_data,
   input  logic [POS_W-1:0] rd_pos,
   output logic [7:0]       rd_byte,
   output logic             full,
   output logic             empty
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

   logic [7:0]       mem [DEPTH];
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic [7:0]       rd_data_ff;
   logic             rd_ok_ff;
   logic             wr_en;

   assign full  = (length_ff == LEN_W'(DEPTH));
   assign empty = (length_ff == '0);
   assign wr_en = ctrl.write && !full;

   always_comb begin
      if (ctrl.clear) begin
         length_in = '0;
      end else if (wr_en) begin
         length_in = length_ff + LEN_W'(1);
      end else begin
         length_in = length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[length_ff[ADDR_W-1:0]] <= wr_data;
      end
   end

   // registered read; position past the fill count reads as zero
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_pos[ADDR_W-1:0]];
      rd_ok_ff   <= (CMP_W'(rd_pos) < CMP_W'(length_ff));
   end

   assign rd_byte = rd_ok_ff ? rd_data_ff : 8'h00;

endmodule

// ----- src/modbus_rtu_read_register_master.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_register_master
// MODBUS RTU master for function 0x04: builds read requests, buffers the
// response and decodes status and register words at frame end.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                      payload
//   req_      in         req_valid / req_stall          kind, start, count, rx byte
//   rsp_      out        rsp_valid / rsp_stall          tx byte, word, status
//   csr_      in/out     APB psel/penable/pwrite/pready slave_address at 0x0
//
// A received byte goes straight into the receive buffer, leaving the block idle.
// A request runs through accept, the bit-serial CRC engine (6 bytes x 8 bits),
// then 8 transmit transfers. A frame end reads the function and byte-count
// bytes, then two bytes per word, through the single registered read port of
// the receive buffer. Output stalls hold the sequencer; req_stall is high
// while busy. Reset clears the sequencer, the fill count and the output valid;
// buffer contents are never cleared, the fill count masks unwritten bytes.
// ----------------------------------------------------------------------------
module modbus_rtu_read_register_master
   import mrr_pkg::*;
#(
   parameter int MAX_REGS       = MAX_REGS_DEF,
   parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [15:0]           req_start_register,
   input  logic [15:0]           req_register_count,
   input  logic [7:0]            req_rx_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [7:0]            rsp_tx_byte,
   output logic [3:0]            rsp_word_index,
   output logic [15:0]           rsp_word_value,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_exception_code,
   output logic [WCOUNT_W-1:0]   rsp_word_count,
   output logic                  rsp_count_saturated,
   output logic                  rsp_last,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // position counter must cover the last word byte and the fill count
   localparam int POS_LIM = (2 * MAX_REGS + 5 > RESPONSE_BYTES + 1) ?
                            (2 * MAX_REGS + 5) : (RESPONSE_BYTES + 1);
   localparam int POS_W   = $clog2(POS_LIM);
   localparam int CRC_STEPS = 6 * 8;

   state_type           state_ff, state_in;
   logic [5:0]          step_ff, step_in;
   logic [WCOUNT_W-1:0] word_ff, word_in;
   logic [WCOUNT_W-1:0] words_ff;
   logic [7:0]          hi_ff;
   logic                func_ok_ff;
   logic [15:0]         start_ff;
   logic [15:0]         count_ff;
   logic [7:0]          slave_address_ff;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_result_kind_ff;
   logic [7:0]          rsp_tx_byte_ff;
   logic [3:0]          rsp_word_index_ff;
   logic [15:0]         rsp_word_value_ff;
   logic [1:0]          rsp_status_ff;
   logic [7:0]          rsp_exception_code_ff;
   logic [WCOUNT_W-1:0] rsp_word_count_ff;
   logic                rsp_count_saturated_ff;
   logic                rsp_last_ff;

   crc_ctrl_type        crc_ctrl;
   rxbuf_ctrl_type      buf_ctrl;
   logic [15:0]         crc;
   logic [POS_W-1:0]    rd_pos;
   logic [7:0]          rd_byte;
   logic                buf_full;
   logic                buf_empty;

   logic                req_fire;
   logic                out_free;
   logic                load_tx, load_stat, load_word;
   logic [2:0]          byte_sel;
   logic [7:0]          frame_byte;
   logic [6:0]          half;
   logic                sat;
   logic [WCOUNT_W-1:0] words;
   logic [1:0]          stat_code;
   logic                go_words;
   logic                word_done;
   logic                csr_write;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_SLAVE_ADDRESS);

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
      end else if (csr_write) begin
         slave_address_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SLAVE_ADDRESS) ?
                       CSR_DATA_W'(slave_address_ff) : '0;

   // ---------------------------------------------------------------- shared units
   mrr_crc u_crc (
      .clock    (clock),
      .ctrl     (crc_ctrl),
      .data_bit (frame_byte[step_ff[2:0]]),
      .crc      (crc)
   );

   mrr_rxbuf #(
      .DEPTH (RESPONSE_BYTES),
      .POS_W (POS_W)
   ) u_rxbuf (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (buf_ctrl),
      .wr_data (req_rx_byte),
      .rd_pos  (rd_pos),
      .rd_byte (rd_byte),
      .full    (buf_full),
      .empty   (buf_empty)
   );

   // ---------------------------------------------------------------- request frame
   // CRC pass walks bytes 0..5 by step[5:3]; transmit walks 0..7 by step[2:0]
   assign byte_sel = (state_ff == S_TX) ? step_ff[2:0] : step_ff[5:3];

   always_comb begin
      case (byte_sel)
         3'd0:    frame_byte = slave_address_ff;
         3'd1:    frame_byte = FUNC_READ_INPUT;
         3'd2:    frame_byte = start_ff[15:8];
         3'd3:    frame_byte = 8'(start_ff & LOW_BYTE_MASK);
         3'd4:    frame_byte = count_ff[15:8];
         3'd5:    frame_byte = 8'(count_ff & LOW_BYTE_MASK);
         3'd6:    frame_byte = 8'(crc & LOW_BYTE_MASK);
         default: frame_byte = crc[15:8];
      endcase
   end

   // ---------------------------------------------------------------- status decode
   // rd_byte holds the byte-count byte while in S_STAT
   always_comb begin
      half  = rd_byte[7:1];
      sat   = (half > 7'(MAX_REGS));
      words = sat ? WCOUNT_W'(MAX_REGS) : half[WCOUNT_W-1:0];
      if (buf_full) begin
         stat_code = ST_OVERFLOW;
      end else if (buf_empty) begin
         stat_code = ST_NO_RESPONSE;
      end else if (!func_ok_ff) begin
         stat_code = ST_EXCEPTION;
      end else begin
         stat_code = ST_OK;
      end
      go_words  = (stat_code == ST_OK) && (words != '0);
      word_done = ((word_ff + WCOUNT_W'(1)) == words_ff);
   end

   // ---------------------------------------------------------------- sequencer outputs
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      crc_ctrl.init  = 1'b0;
      crc_ctrl.shift = (state_ff == S_CRC);
      buf_ctrl.clear = 1'b0;
      buf_ctrl.write = 1'b0;
      load_tx        = (state_ff == S_TX) && out_free;
      load_stat      = (state_ff == S_STAT) && out_free;
      load_word      = (state_ff == S_WOUT) && out_free;
      if (state_ff == S_IDLE && req_valid) begin
         crc_ctrl.init  = (req_kind == KIND_REQUEST);
         buf_ctrl.clear = (req_kind == KIND_REQUEST);
         buf_ctrl.write = (req_kind == KIND_RX_BYTE);
      end
      unique case (state_ff)
         S_RD1:          rd_pos = POS_W'(POS_FUNC);
         S_RD2, S_STAT:  rd_pos = POS_W'(POS_BYTE_COUNT);
         S_WHI:          rd_pos = POS_W'({word_ff, 1'b0}) + POS_W'(POS_DATA);
         S_WLO, S_WOUT:  rd_pos = POS_W'({word_ff, 1'b0}) + POS_W'(POS_DATA + 1);
         default:        rd_pos = '0;
      endcase
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      word_in  = word_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_REQUEST: begin
                     state_in = S_CRC;
                     step_in  = '0;
                  end
                  KIND_FRAME_END: state_in = S_RD1;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_CRC: begin
            if (step_ff == 6'(CRC_STEPS - 1)) begin
               state_in = S_TX;
               step_in  = '0;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_TX: begin
            if (load_tx) begin
               step_in = step_ff + 6'd1;
               if (step_ff[2:0] == 3'd7) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_STAT;
         S_STAT: begin
            if (load_stat) begin
               word_in  = '0;
               state_in = go_words ? S_WHI : S_IDLE;
            end
         end
         S_WHI: state_in = S_WLO;
         S_WLO: state_in = S_WOUT;
         S_WOUT: begin
            if (load_word) begin
               word_in  = word_ff + WCOUNT_W'(1);
               state_in = word_done ? S_IDLE : S_WHI;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      word_ff <= word_in;
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire && req_kind == KIND_REQUEST) begin
         start_ff <= req_start_register - 16'd1;
         count_ff <= (req_register_count > 16'(MAX_REGS)) ?
                     16'(MAX_REGS) : req_register_count;
      end
      if (state_ff == S_RD2) begin
         func_ok_ff <= (rd_byte == FUNC_READ_INPUT);
      end
      if (load_stat) begin
         words_ff <= words;
      end
      if (state_ff == S_WLO) begin
         hi_ff <= rd_byte;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_tx || load_stat || load_word) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_tx || load_stat || load_word) begin
         rsp_result_kind_ff     <= RK_TX_BYTE;
         rsp_tx_byte_ff         <= '0;
         rsp_word_index_ff      <= '0;
         rsp_word_value_ff      <= '0;
         rsp_status_ff          <= ST_OK;
         rsp_exception_code_ff  <= '0;
         rsp_word_count_ff      <= '0;
         rsp_count_saturated_ff <= 1'b0;
         rsp_last_ff            <= 1'b0;
         if (load_tx) begin
            rsp_tx_byte_ff <= frame_byte;
            rsp_last_ff    <= (step_ff[2:0] == 3'd7);
         end
         if (load_stat) begin
            rsp_result_kind_ff <= RK_STATUS;
            rsp_status_ff      <= stat_code;
            rsp_last_ff        <= !go_words;
            if (stat_code == ST_EXCEPTION) begin
               rsp_exception_code_ff <= rd_byte;
            end
            if (stat_code == ST_OK) begin
               rsp_word_count_ff      <= words;
               rsp_count_saturated_ff <= sat;
            end
         end
         if (load_word) begin
            rsp_result_kind_ff <= RK_WORD;
            rsp_word_index_ff  <= word_ff[3:0];
            rsp_word_value_ff  <= {hi_ff, rd_byte};
            rsp_last_ff        <= word_done;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_result_kind_ff;
   assign rsp_tx_byte         = rsp_tx_byte_ff;
   assign rsp_word_index      = rsp_word_index_ff;
   assign rsp_word_value      = rsp_word_value_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_exception_code  = rsp_exception_code_ff;
   assign rsp_word_count      = rsp_word_count_ff;
   assign rsp_count_saturated = rsp_count_saturated_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ----- tb/modbus_master_checker.sv -----
// ----------------------------------------------------------------------------
// modbus_master_checker
// Watches the request, response and CSR ports of the read-input-registers
// master. It predicts every response transfer in order and compares each
// field.
// ----------------------------------------------------------------------------
module modbus_master_checker
   import mrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [15:0]           req_start_register,
   input  logic [15:0]           req_register_count,
   input  logic [7:0]            req_rx_byte,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_result_kind,
   input  logic [7:0]            rsp_tx_byte,
   input  logic [3:0]            rsp_word_index,
   input  logic [15:0]           rsp_word_value,
   input  logic [1:0]            rsp_status,
   input  logic [7:0]            rsp_exception_code,
   input  logic [WCOUNT_W-1:0]   rsp_word_count,
   input  logic                  rsp_count_saturated,
   input  logic                  rsp_last,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,

   output int                    error_count,
   output int                    outputs_pending
);

   localparam logic [CSR_ADDR_W-1:0] CSR_SLAVE_ADDRESS =
      CSR_ADDR_W'(4 * int'(REG_SLAVE_ADDRESS));

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [7:0]          tx_byte;
      logic [3:0]          word_index;
      logic [15:0]         word_value;
      logic [1:0]          status;
      logic [7:0]          exception_code;
      logic [WCOUNT_W-1:0] word_count;
      logic                count_saturated;
      logic                last;
   } master_out_type;

   master_out_type outputs_due[$];
   master_out_type seen;
   master_out_type want;

   logic [7:0] slave_address;
   logic [7:0] rx_bytes [RESPONSE_BYTES_DEF];
   int         rx_fill;
   bit         rx_full;
   int         mismatches = 0;

   initial begin
      error_count     = 0;
      outputs_pending = 0;
   end

   // CRC-16/MODBUS over the six query bytes, first byte in the top bits
   function automatic logic [15:0] modbus_crc16(input logic [47:0] query);
      logic [15:0] crc;
      int          i;
      int          b;
      crc = CRC_INIT;
      for (i = 0; i < 6; i++) begin
         crc ^= {8'h00, query[47 - 8*i -: 8]};
         for (b = 0; b < 8; b++) begin
            if (crc[0])
               crc = (crc >> 1) ^ CRC_POLY;
            else
               crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // bytes never received read as zero
   function automatic logic [7:0] rx_at(input int idx);
      if (idx < RESPONSE_BYTES_DEF && idx < rx_fill)
         return rx_bytes[idx];
      return 8'h00;
   endfunction

   task automatic step_master(input logic [1:0] kind, input logic [15:0] start,
                              input logic [15:0] count, input logic [7:0] rxb);
      logic [15:0]    first_reg;
      logic [15:0]    qty;
      logic [15:0]    crc;
      logic [47:0]    query;
      master_out_type r;
      int             half;
      int             words;
      int             i;
      words = 0;
      case (kind)
         KIND_REQUEST: begin
            first_reg = start - 16'd1;
            qty       = (count > MAX_REGS_DEF) ? 16'(MAX_REGS_DEF) : count;
            rx_fill   = 0;
            rx_full   = 1'b0;
            query     = {slave_address, FUNC_READ_INPUT, first_reg, qty};
            crc       = modbus_crc16(query);
            for (i = 0; i < 8; i++) begin
               r             = '0;
               r.result_kind = RK_TX_BYTE;
               if (i < 6)
                  r.tx_byte = query[47 - 8*i -: 8];
               else if (i == 6)
                  r.tx_byte = crc[7:0];
               else
                  r.tx_byte = crc[15:8];
               r.last = (i == 7);
               outputs_due.push_back(r);
            end
         end
         KIND_RX_BYTE: begin
            if (!rx_full && rx_fill < RESPONSE_BYTES_DEF) begin
               rx_bytes[rx_fill] = rxb;
               rx_fill++;
               if (rx_fill >= RESPONSE_BYTES_DEF)
                  rx_full = 1'b1;
            end
         end
         KIND_FRAME_END: begin
            r             = '0;
            r.result_kind = RK_STATUS;
            r.last        = 1'b1;
            if (rx_full) begin
               r.status = ST_OVERFLOW;
            end else if (rx_fill == 0) begin
               r.status = ST_NO_RESPONSE;
            end else if (rx_at(POS_FUNC) != FUNC_READ_INPUT) begin
               r.status         = ST_EXCEPTION;
               r.exception_code = rx_at(POS_BYTE_COUNT);
            end else begin
               half              = int'(rx_at(POS_BYTE_COUNT)) / 2;
               words             = (half > MAX_REGS_DEF) ? MAX_REGS_DEF : half;
               r.status          = ST_OK;
               r.word_count      = WCOUNT_W'(words);
               r.count_saturated = (half > MAX_REGS_DEF);
               r.last            = (words == 0);
            end
            outputs_due.push_back(r);
            for (i = 0; i < words; i++) begin
               r             = '0;
               r.result_kind = RK_WORD;
               r.word_index  = i[3:0];
               r.word_value  = {rx_at(POS_DATA + 2*i), rx_at(POS_DATA + 2*i + 1)};
               r.last        = (i == words - 1);
               outputs_due.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slave_address = 8'd1;
         rx_fill       = 0;
         rx_full       = 1'b0;
         outputs_due.delete();
      end else begin
         // response side first: a transfer at this edge cannot stem from a
         // request accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_result_kind, rsp_tx_byte, rsp_word_index, rsp_word_value,
                    rsp_status, rsp_exception_code, rsp_word_count,
                    rsp_count_saturated, rsp_last};
            if (outputs_due.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                        $time, seen);
               mismatches++;
            end else begin
               want = outputs_due.pop_front();
               check_field("result_kind", want.result_kind, seen.result_kind);
               check_field("tx_byte", want.tx_byte, seen.tx_byte);
               check_field("word_index", want.word_index, seen.word_index);
               check_field("word_value", want.word_value, seen.word_value);
               check_field("status", want.status, seen.status);
               check_field("exception_code", want.exception_code, seen.exception_code);
               check_field("word_count", want.word_count, seen.word_count);
               check_field("count_saturated", want.count_saturated,
                           seen.count_saturated);
               check_field("last", want.last, seen.last);
            end
         end
         if (req_valid && !req_stall)
            step_master(req_kind, req_start_register, req_register_count, req_rx_byte);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_SLAVE_ADDRESS)
            slave_address = csr_pwdata[7:0];
      end
      error_count     <= mismatches;
      outputs_pending <= outputs_due.size();
   end

endmodule

// ----- tb/modbus_rtu_read_register_master_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_register_master_tb
// Drives request, received-byte, frame-end and ignored-kind items into the
// MODBUS master, moves the slave address through several values over the CSR
// port and stalls the response side at random. The checker predicts and compares.
// ----------------------------------------------------------------------------
module modbus_rtu_read_register_master_tb;
   import mrr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SLAVE_ADDRESS =
      CSR_ADDR_W'(4 * int'(REG_SLAVE_ADDRESS));
   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam logic [7:0] EXCEPTION_FLAG = 8'h80;
   // longest busy stretch of the block (a request), with margin
   localparam int QUIET_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_kind;
   logic [15:0]           req_start_register;
   logic [15:0]           req_register_count;
   logic [7:0]            req_rx_byte;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_result_kind;
   logic [7:0]            rsp_tx_byte;
   logic [3:0]            rsp_word_index;
   logic [15:0]           rsp_word_value;
   logic [1:0]            rsp_status;
   logic [7:0]            rsp_exception_code;
   logic [WCOUNT_W-1:0]   rsp_word_count;
   logic                  rsp_count_saturated;
   logic                  rsp_last;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int         error_count;
   int         outputs_pending;
   int         items_sent = 0;
   bit         idle_on = 1'b1;     // random gaps on both sides when set
   logic [7:0] slave_addr = 8'd1;  // address the block currently holds

   always #10 clock = ~clock;

   modbus_rtu_read_register_master dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_start_register  (req_start_register),
      .req_register_count  (req_register_count),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_word_index      (rsp_word_index),
      .rsp_word_value      (rsp_word_value),
      .rsp_status          (rsp_status),
      .rsp_exception_code  (rsp_exception_code),
      .rsp_word_count      (rsp_word_count),
      .rsp_count_saturated (rsp_count_saturated),
      .rsp_last            (rsp_last),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   modbus_master_checker chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_start_register  (req_start_register),
      .req_register_count  (req_register_count),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_word_index      (rsp_word_index),
      .rsp_word_value      (rsp_word_value),
      .rsp_status          (rsp_status),
      .rsp_exception_code  (rsp_exception_code),
      .rsp_word_count      (rsp_word_count),
      .rsp_count_saturated (rsp_count_saturated),
      .rsp_last            (rsp_last),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_pready          (csr_pready),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .error_count         (error_count),
      .outputs_pending     (outputs_pending)
   );

   // Receiver back-pressure: about 19% of cycles stalled while idling is on,
   // none while it is off.
   always @(posedge clock)
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 19);

   // One input transfer. Valid only drops for a random gap, never because of
   // stall, and the payload holds until the block takes it.
   task automatic push_item(input logic [1:0] kind, input logic [15:0] start,
                            input logic [15:0] count, input logic [7:0] rxb);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_start_register <= start;
      req_register_count <= count;
      req_rx_byte        <= rxb;
      do @(posedge clock); while (req_stall);
      // ignored items do not count toward the run length
      if (kind != KIND_UNUSED)
         items_sent++;
   endtask

   // unused payload fields carry random values so every bit toggles
   task automatic send_request(input logic [15:0] start, input logic [15:0] count);
      push_item(KIND_REQUEST, start, count, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      push_item(KIND_RX_BYTE, 16'($urandom), 16'($urandom), b);
   endtask

   task automatic end_frame();
      push_item(KIND_FRAME_END, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // Drop valid, wait until every predicted transfer has arrived, then give
   // the block time to finish any item that produces no transfer.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outputs_pending != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready
   task automatic csr_write(input logic [7:0] addr_value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_SLAVE_ADDRESS;
      csr_pwdata  <= {24'($urandom), addr_value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      slave_addr = addr_value;
   endtask

   // One random exchange. Mostly a request followed by a well-formed reply
   // with random content; the rest are exceptions, overflows, silence,
   // broken replies and raw noise.
   task automatic random_exchange();
      int         sel;
      int         n;
      int         bc;
      int         drop;
      int         i;
      logic [7:0] func;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         repeat ($urandom_range(1, 4))
            push_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      8'($urandom));
         return;
      end
      send_request(16'($urandom),
                   ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 20))
                                               : 16'($urandom));
      if (sel < 60) begin
         // good reply: addr, function, byte count, words, two CRC bytes
         n    = $urandom_range(0, 19);
         bc   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : 2 * n;
         drop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * n + 2) : 0;
         send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : slave_addr);
         send_byte(FUNC_READ_INPUT);
         send_byte(8'(bc));
         for (i = 0; i < 2 * n + 2 - drop; i++)
            send_byte(8'($urandom));
         end_frame();
         if ($urandom_range(0, 5) == 0)
            end_frame();
         // late bytes land behind the kept buffer
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end_frame();
         end
      end else if (sel < 72) begin
         func = $urandom_range(0, 1) ? (FUNC_READ_INPUT | EXCEPTION_FLAG) : 8'($urandom);
         send_byte(slave_addr);
         send_byte(func);
         send_byte(8'($urandom));
         send_byte(8'($urandom));
         send_byte(8'($urandom));
         end_frame();
      end else if (sel < 76) begin
         repeat (RESPONSE_BYTES_DEF + $urandom_range(0, 6)) send_byte(8'($urandom));
         end_frame();
      end else if (sel < 88) begin
         end_frame();
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end_frame();
      end
   endtask

   initial begin : stimulus
      logic [7:0] phase_addr [4];
      int         phase;
      int         phase_target;
      int         wait_count;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_kind           <= KIND_REQUEST;
      req_start_register <= '0;
      req_register_count <= '0;
      req_rx_byte        <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset address, field extremes, every status but overflow ----
      send_request(16'h0000, 16'h0000);          // start wraps to 0xFFFF
      end_frame();                               // nothing received
      push_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);  // ignored kind
      send_request(16'h0001, 16'd16);
      send_byte(slave_addr);
      send_byte(FUNC_READ_INPUT | EXCEPTION_FLAG);
      send_byte(8'h02);
      end_frame();                               // exception reply
      end_frame();                               // repeated frame end
      send_request(16'hFFFF, 16'hFFFF);          // count clamps
      send_byte(slave_addr);
      send_byte(FUNC_READ_INPUT);
      send_byte(8'hFF);                          // byte count saturates
      send_byte(8'hAB);
      send_byte(8'hCD);                          // remaining words read zero
      end_frame();
      send_request(16'h8000, 16'd17);
      send_byte(slave_addr);
      end_frame();                               // function byte missing
      send_request(16'h1234, 16'd0);
      send_byte(8'h11);
      send_byte(FUNC_READ_INPUT);
      send_byte(8'h00);
      end_frame();                               // ok with no words
      send_byte(8'h00);                          // appended after frame end

      // ---- random phases, each with its own slave address ----
      // the last exchange of a phase may overrun the target
      phase_addr[0] = 8'h00;
      phase_addr[1] = 8'hFF;
      phase_addr[2] = 8'($urandom);
      phase_addr[3] = 8'h5A;
      for (phase = 0; phase < 4; phase++) begin
         settle();
         csr_write(phase_addr[phase]);
         idle_on      = (phase != 2);  // phase 2 runs with no gaps at all
         phase_target = items_sent + 34;
         while (items_sent < phase_target)
            random_exchange();
      end
      idle_on = 1'b1;

      // ---- drain and verdict ----
      req_valid <= 1'b0;
      wait_count = 0;
      while (outputs_pending != 0 && wait_count < 5000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
      if (error_count == 0 && outputs_pending == 0) begin
         $display("Verification passed");
      end else begin
         if (outputs_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, outputs_pending);
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
